// ----- rtl/azs_pkg.sv -----
// ----------------------------------------------------------------------------
// azs_pkg
// Shared types and constants of the adaptive zoom smoother and scaler.
// ----------------------------------------------------------------------------
package azs_pkg;

  // field widths fixed by the item format
  localparam int SCALE_W   = 18;
  localparam int COORD_W   = 32;
  localparam int CFG_IDX_W = 1;

  typedef logic signed [SCALE_W-1:0] scale_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

  // item opcodes
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_COORD = 1'b1;

  // register indexes
  localparam cfg_idx_t REG_MIN_SCALE = 1'b0;
  localparam cfg_idx_t REG_MAX_SCALE = 1'b1;

  // reset values of the registers
  localparam scale_t MIN_SCALE_RST = 18'sd0;
  localparam scale_t MAX_SCALE_RST = 18'sd65536;

  // classified item as held in the queue
  typedef struct packed {
    logic   is_frame;
    scale_t target;
    coord_t x;
    coord_t y;
  } entry_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  // frame sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_ALPHA,
    ST_STEP,
    ST_APPLY
  } fsm_t;

endpackage

// ----- rtl/azs_if.sv -----
// ----------------------------------------------------------------------------
// azs_if
// Valid/ready channels for input items and result words.
// ----------------------------------------------------------------------------
interface azs_in_if import azs_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   op;
  scale_t target_scale;
  coord_t coord_x;
  coord_t coord_y;

  modport source (output valid, op, target_scale, coord_x, coord_y, input ready);
  modport sink (input valid, op, target_scale, coord_x, coord_y, output ready);
endinterface

interface azs_out_if import azs_pkg::*; ();
  logic   valid;
  logic   ready;
  scale_t scale_out;
  coord_t x_out;
  coord_t y_out;

  modport source (output valid, scale_out, x_out, y_out, input ready);
  modport sink (input valid, scale_out, x_out, y_out, output ready);
endinterface

// ----- rtl/azs_front.sv -----
// ----------------------------------------------------------------------------
// azs_front
// Accepts input words, classifies them as frame or coordinate items and
// holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module azs_front import azs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  azs_in_if.sink    items,
  output head_t     head,
  input  logic      pop
);

  entry_t      mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  entry_t      entry_in;

  // accept while a slot is free
  assign items.ready = (count != 2'd2);
  assign push        = items.valid && items.ready;

  // classify the incoming word
  always_comb begin
    entry_in.is_frame = (items.op == OP_FRAME);
    entry_in.target   = items.target_scale;
    entry_in.x        = items.coord_x;
    entry_in.y        = items.coord_y;
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry_in;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.entry = mem[rd_ptr];

endmodule

// ----- rtl/azs_back.sv -----
// ----------------------------------------------------------------------------
// azs_back
// Executes queued items: scales coordinate pairs at one per cycle when not stalled
// and runs the frame smoothing step, through a radix-2 divider for a positive span.
// ----------------------------------------------------------------------------
module azs_back import azs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  scale_t    min_scale,
  input  scale_t    max_scale,
  input  head_t     head,
  output logic      pop,
  azs_out_if.source results
);

  localparam int ALPHA_W = FRAC_BITS + 1;
  localparam int NUM_W   = FRAC_BITS + SCALE_W;
  localparam int PROD_W  = SCALE_W + 1 + ALPHA_W + 1;
  localparam int CNT_W   = $clog2(FRAC_BITS);
  localparam int MUL_W   = SCALE_W + COORD_W;
  localparam logic [CNT_W-1:0]     CNT_LAST  = CNT_W'(FRAC_BITS - 1);
  localparam logic [ALPHA_W-1:0]   ALPHA_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  // one minus one thirty-second, the largest alpha reduction
  localparam logic [FRAC_BITS-1:0] K_GAIN    =
      FRAC_BITS'((64'd1 << FRAC_BITS) - (64'd1 << (FRAC_BITS - 5)));
  localparam logic signed [PROD_W:0] HALF    = (PROD_W + 1)'(64'd1 << (FRAC_BITS - 1));

  fsm_t state;
  fsm_t state_next;

  scale_t                     cur_scale;
  logic signed [SCALE_W:0]    delta;
  logic [SCALE_W-1:0]         bias;
  logic [SCALE_W-1:0]         span;
  logic                       span_pos;
  logic [SCALE_W-1:0]         rem;
  logic [FRAC_BITS-1:0]       num_lo;
  logic [FRAC_BITS-1:0]       quo;
  logic [CNT_W-1:0]           cnt;
  logic [ALPHA_W-1:0]         alpha;
  logic signed [PROD_W-1:0]   step_prod;

  // pipeline stage and output register
  logic   p_vld;
  scale_t p_scale;
  coord_t p_x;
  coord_t p_y;
  logic   o_vld;
  scale_t o_scale;
  coord_t o_x;
  coord_t o_y;
  logic   o_load;
  logic   p_can_load;

  // sequencer outputs
  logic coord_issue;
  logic frame_start;
  logic frame_issue;

  // frame set-up terms
  logic signed [SCALE_W:0] span_full;
  logic signed [SCALE_W:0] bias_full;
  logic [SCALE_W-1:0]      bias_clamp;
  logic [NUM_W-1:0]        num;

  // divider step
  logic [SCALE_W:0]        rem_sh;
  logic                    rem_ge;
  logic [SCALE_W:0]        rem_sub;

  // smoothing step
  logic signed [PROD_W:0]  prod_ext;
  logic signed [PROD_W:0]  rounded;
  logic signed [PROD_W:0]  step_sh;
  scale_t                  new_scale;

  // coordinate products
  logic signed [MUL_W-1:0] px;
  logic signed [MUL_W-1:0] py;
  logic signed [MUL_W-1:0] px_sh;
  logic signed [MUL_W-1:0] py_sh;

  // output handshake
  assign o_load     = p_vld && (!o_vld || results.ready);
  assign p_can_load = !p_vld || o_load;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (head.valid && head.entry.is_frame) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD:  state_next = span_pos ? ST_DIV : ST_STEP;
      ST_DIV: begin
        if (cnt == CNT_LAST) begin
          state_next = ST_ALPHA;
        end
      end
      ST_ALPHA: state_next = ST_STEP;
      ST_STEP:  state_next = ST_APPLY;
      ST_APPLY: begin
        if (p_can_load) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    coord_issue = 1'b0;
    frame_start = 1'b0;
    frame_issue = 1'b0;
    case (state)
      ST_IDLE: begin
        coord_issue = head.valid && !head.entry.is_frame && p_can_load;
        frame_start = head.valid && head.entry.is_frame;
      end
      ST_APPLY: frame_issue = p_can_load;
      default: begin
        coord_issue = 1'b0;
      end
    endcase
  end

  assign pop = coord_issue || frame_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // clamped bias against the current span
  always_comb begin
    span_full = {max_scale[SCALE_W-1], max_scale} - {min_scale[SCALE_W-1], min_scale};
    bias_full = {max_scale[SCALE_W-1], max_scale}
              - {head.entry.target[SCALE_W-1], head.entry.target};
    if (bias_full < 0) begin
      bias_clamp = '0;
    end else if ((span_full > 0) && (bias_full > span_full)) begin
      bias_clamp = span_full[SCALE_W-1:0];
    end else begin
      bias_clamp = bias_full[SCALE_W-1:0];
    end
  end

  assign num = NUM_W'(K_GAIN * bias);

  // one quotient bit per cycle
  assign rem_sh  = {rem, num_lo[FRAC_BITS-1]};
  assign rem_ge  = (rem_sh >= {1'b0, span});
  assign rem_sub = rem_sh - {1'b0, span};

  // add half to a positive product, subtract half from a negative one, then floor shift
  always_comb begin
    prod_ext  = {step_prod[PROD_W-1], step_prod};
    rounded   = (prod_ext >= 0) ? (prod_ext + HALF) : (prod_ext - HALF);
    step_sh   = rounded >>> FRAC_BITS;
    new_scale = cur_scale + step_sh[SCALE_W-1:0];
  end

  // frame datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        delta    <= {head.entry.target[SCALE_W-1], head.entry.target}
                  - {cur_scale[SCALE_W-1], cur_scale};
        bias     <= bias_clamp;
        span     <= span_full[SCALE_W-1:0];
        span_pos <= (span_full > 0);
      end
      ST_LOAD: begin
        rem    <= num[NUM_W-1:FRAC_BITS];
        num_lo <= num[FRAC_BITS-1:0];
        quo    <= '0;
        cnt    <= '0;
        alpha  <= ALPHA_ONE;
      end
      ST_DIV: begin
        rem    <= rem_ge ? rem_sub[SCALE_W-1:0] : rem_sh[SCALE_W-1:0];
        num_lo <= {num_lo[FRAC_BITS-2:0], 1'b0};
        quo    <= {quo[FRAC_BITS-2:0], rem_ge};
        cnt    <= cnt + 1'b1;
      end
      ST_ALPHA: alpha <= ALPHA_ONE - {1'b0, quo};
      ST_STEP:  step_prod <= delta * $signed({1'b0, alpha});
      default: begin
        rem <= rem;
      end
    endcase
  end

  // smoothed scale
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_scale <= MIN_SCALE_RST;
    end else if (frame_issue) begin
      cur_scale <= new_scale;
    end
  end

  // coordinate scaling
  assign px    = $signed(head.entry.x) * cur_scale;
  assign py    = $signed(head.entry.y) * cur_scale;
  assign px_sh = px >>> FRAC_BITS;
  assign py_sh = py >>> FRAC_BITS;

  // result stage
  always_ff @(posedge clk) begin
    if (coord_issue) begin
      p_scale <= cur_scale;
      p_x     <= px_sh[COORD_W-1:0];
      p_y     <= py_sh[COORD_W-1:0];
    end else if (frame_issue) begin
      p_scale <= new_scale;
      p_x     <= '0;
      p_y     <= '0;
    end
    if (o_load) begin
      o_scale <= p_scale;
      o_x     <= p_x;
      o_y     <= p_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
      o_vld <= 1'b0;
    end else begin
      if (coord_issue || frame_issue) begin
        p_vld <= 1'b1;
      end else if (o_load) begin
        p_vld <= 1'b0;
      end
      if (o_load) begin
        o_vld <= 1'b1;
      end else if (results.ready) begin
        o_vld <= 1'b0;
      end
    end
  end

  assign results.valid     = o_vld;
  assign results.scale_out = o_scale;
  assign results.x_out     = o_x;
  assign results.y_out     = o_y;

endmodule

// ----- rtl/adaptive_zoom_smoother_scaler.sv -----
// ----------------------------------------------------------------------------
// adaptive_zoom_smoother_scaler
// Smoothed zoom scale with per-pixel coordinate scaling.
// ----------------------------------------------------------------------------
// Usage:
//   items   : input words, op selects a frame step (target_scale) or a
//             coordinate pair (coord_x, coord_y) to be scaled
//   results : one word per item, carrying the scale after the item and the
//             scaled pair (zero for a frame item)
//   cfg_*   : register writes, min_scale and max_scale, only while idle
// Path: a coordinate word passes the queue, the pipeline stage and the output register.
// Throughput: coordinate items run at one per cycle while no frame item or stall
//   holds the back end. A frame item holds it through the load, divide, alpha,
//   step and apply states; the radix-2 divider that forms the smoothing gain
//   gives one quotient bit a cycle and is skipped with a span of zero or less.
// Reset: registers return to min_scale 0 and max_scale 1.0, the scale to 0,
//   queue and result stages empty.
// Stall: a held result keeps the output word; the pipeline stage and the
//   two-entry queue keep taking items until they fill, then items.ready drops.
// ----------------------------------------------------------------------------
module adaptive_zoom_smoother_scaler import azs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  azs_in_if.sink    items,
  azs_out_if.source results,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_index,
  input  scale_t    cfg_data
);

  scale_t min_scale;
  scale_t max_scale;
  head_t  head;
  logic   pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_scale <= MIN_SCALE_RST;
      max_scale <= MAX_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_SCALE: min_scale <= cfg_data;
        REG_MAX_SCALE: max_scale <= cfg_data;
        default:       min_scale <= min_scale;
      endcase
    end
  end

  azs_front u_front (
    .clk   (clk),
    .rst   (rst),
    .items (items),
    .head  (head),
    .pop   (pop)
  );

  azs_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .min_scale (min_scale),
    .max_scale (max_scale),
    .head      (head),
    .pop       (pop),
    .results   (results)
  );

endmodule

// ----- rtl/azs_checker.sv -----
// ----------------------------------------------------------------------------
// azs_checker
// Port-level checks of the zoom scaler: ordering of words in and out,
// bounded occupancy and output hold under stall.
// ----------------------------------------------------------------------------
module azs_checker import azs_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input scale_t scale_out,
  input coord_t x_out,
  input coord_t y_out
);

  // queue, frame sequencer, result stage and output register
  localparam logic [2:0] MAX_HELD = 3'd5;

  logic [2:0] held;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   held <= held + 3'd1;
        2'b01:   held <= held - 3'd1;
        default: held <= held;
      endcase
    end
  end

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // no result word without an item behind it
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (held != 3'd0))
    else $error("result word without an accepted item");

  // occupancy stays within the storage of the block
  a_bounded: assert property (@(posedge clk) disable iff (rst)
    held <= MAX_HELD)
    else $error("more words held than storage allows");

  // stalled result holds its word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(scale_out)
      && $stable(x_out) && $stable(y_out))
    else $error("stalled result changed");

endmodule

bind adaptive_zoom_smoother_scaler azs_checker u_azs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .scale_out (results.scale_out),
  .x_out     (results.x_out),
  .y_out     (results.y_out)
);

// ----- tb/sv/zoom_checker.sv -----
// ----------------------------------------------------------------------------
// zoom_checker
// Watches the item and result channels of the zoom smoother and scaler,
// keeps its own copy of the smoothed scale and both scale registers, and
// compares every result word against the oldest predicted word.
// ----------------------------------------------------------------------------
module zoom_checker import azs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  azs_in_if        items,
  azs_out_if       results,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_index,
  input  scale_t   cfg_data,
  output int       fail_count,
  output int       outstanding,
  output int       frames_checked,
  output int       coords_checked
);

  // gain runs from unity down to 1/32 of unity
  localparam longint UNITY      = longint'(1) << FRAC_BITS;
  localparam longint GAIN_FLOOR = UNITY / 32;
  localparam longint ROUND_BIAS = longint'(1) << (FRAC_BITS - 1);

  typedef struct {
    logic   is_frame;
    scale_t scale;
    coord_t x;
    coord_t y;
  } zoom_word_t;

  scale_t     lo_scale;
  scale_t     hi_scale;
  scale_t     zoom;
  zoom_word_t predicted_words[$];

  // one frame step of the smoothed scale towards the target
  function automatic scale_t smoothed_scale(scale_t target);
    longint delta;
    longint span;
    longint bias;
    longint gain;
    longint step;
    delta = longint'(target) - longint'(zoom);
    span  = longint'(hi_scale) - longint'(lo_scale);
    bias  = longint'(hi_scale) - longint'(target);
    if (bias < 0) bias = 0;
    if (span > 0 && bias > span) bias = span;
    gain = UNITY;
    if (span > 0) gain = gain - ((UNITY - GAIN_FLOOR) * bias) / span;
    step = delta * gain;
    step = (step >= 0) ? step + ROUND_BIAS : step - ROUND_BIAS;
    step = step >>> FRAC_BITS;
    return scale_t'(longint'(zoom) + step);
  endfunction

  // coordinate times scale, floor shift, keep the low 32 bits
  function automatic coord_t scaled_coord(coord_t c);
    longint prod;
    prod = (longint'(c) * longint'(zoom)) >>> FRAC_BITS;
    return coord_t'(prod);
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    fail_count++;
    $display("%0t: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin : track
    zoom_word_t want;
    zoom_word_t word;
    if (rst) begin
      lo_scale = MIN_SCALE_RST;
      hi_scale = MAX_SCALE_RST;
      zoom     = MIN_SCALE_RST;
      predicted_words.delete();
    end else begin
      // register writes leave the current scale alone
      if (cfg_we) begin
        if (cfg_index == REG_MIN_SCALE) lo_scale = cfg_data;
        else if (cfg_index == REG_MAX_SCALE) hi_scale = cfg_data;
      end
      // outgoing word against the oldest prediction
      if (results.valid && results.ready) begin
        if (predicted_words.size() == 0) begin
          flag_mismatch("unexpected result word, scale_out", results.scale_out, 0);
        end else begin
          want = predicted_words.pop_front();
          if (results.scale_out !== want.scale)
            flag_mismatch("scale_out", results.scale_out, want.scale);
          if (results.x_out !== want.x) flag_mismatch("x_out", results.x_out, want.x);
          if (results.y_out !== want.y) flag_mismatch("y_out", results.y_out, want.y);
          if (want.is_frame) frames_checked++;
          else coords_checked++;
        end
      end
      // incoming word, predict its result
      if (items.valid && items.ready) begin
        if (items.op == OP_FRAME) begin
          zoom          = smoothed_scale(items.target_scale);
          word.is_frame = 1'b1;
          word.x        = '0;
          word.y        = '0;
        end else begin
          word.is_frame = 1'b0;
          word.x        = scaled_coord(items.coord_x);
          word.y        = scaled_coord(items.coord_y);
        end
        word.scale = zoom;
        predicted_words.push_back(word);
      end
    end
    outstanding = predicted_words.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the zoom smoother and scaler: a directed pass over the scale
// extremes and span cases, then random phases under several register
// settings with bursty input, a stalling receiver and one long hold-off.
// ----------------------------------------------------------------------------
module tb_top import azs_pkg::*;;

  localparam int SCALE_LO    = -65536;
  localparam int SCALE_HI    = 65536;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 520;

  logic     clk = 1'b0;
  logic     rst;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  scale_t   cfg_data;

  azs_in_if  items_ch ();
  azs_out_if results_ch ();

  int fail_count;
  int outstanding;
  int frames_checked;
  int coords_checked;

  int burst_left;
  int words_sent;
  int settings_used;
  int cur_lo;
  int cur_hi;
  bit hold_done;

  adaptive_zoom_smoother_scaler uut (
    .clk       (clk),
    .rst       (rst),
    .items     (items_ch),
    .results   (results_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  zoom_checker watch (
    .clk            (clk),
    .rst            (rst),
    .items          (items_ch),
    .results        (results_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .frames_checked (frames_checked),
    .coords_checked (coords_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("timed out with %0d result words outstanding", outstanding);
    $display("Regression FAIL");
    $finish;
  end

  // receiver: stretches of random ready patterns, one long hold-off
  initial begin
    int mode;
    int stretch;
    results_ch.ready = 1'b0;
    forever begin
      mode    = $urandom_range(3);
      stretch = $urandom_range(200, 20);
      repeat (stretch) begin
        @(negedge clk);
        if (!hold_done && words_sent >= HOLD_AFTER) begin
          results_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0: results_ch.ready <= 1'b1;
          1: results_ch.ready <= 1'($urandom_range(1));
          2: results_ch.ready <= ($urandom_range(3) == 0);
          default: results_ch.ready <= ~results_ch.ready;
        endcase
      end
    end
  end

  function automatic int clip_scale(int v);
    if (v < SCALE_LO) return SCALE_LO;
    if (v > SCALE_HI) return SCALE_HI;
    return v;
  endfunction

  function automatic int any_scale();
    return int'($urandom_range(SCALE_HI - SCALE_LO)) + SCALE_LO;
  endfunction

  // targets cluster on the register values and the range ends
  function automatic int frame_target();
    case ($urandom_range(9))
      0: return cur_lo;
      1: return cur_hi;
      2: return clip_scale(cur_lo - 1);
      3: return clip_scale(cur_hi + 1);
      4: return SCALE_LO;
      5: return SCALE_HI;
      6: return clip_scale(cur_lo + int'($urandom_range(255)));
      default: return any_scale();
    endcase
  endfunction

  function automatic coord_t any_coord();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return coord_t'(int'($urandom_range(4095)) - 2048);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // offer one word, in bursts with random gaps between them
  task automatic push_word(logic op, int target, coord_t x, coord_t y);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        items_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(120, 40) : $urandom_range(12, 1);
    end
    items_ch.valid        <= 1'b1;
    items_ch.op           <= op;
    items_ch.target_scale <= scale_t'(target);
    items_ch.coord_x      <= x;
    items_ch.coord_y      <= y;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    words_sent++;
  endtask

  // stop offering and wait for every predicted word to come out
  task automatic drain_block();
    items_ch.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // write both scale registers, in random order
  task automatic load_scales(int lo, int hi);
    int first;
    first = $urandom_range(1);
    for (int k = 0; k < 2; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= (k == first) ? REG_MIN_SCALE : REG_MAX_SCALE;
      cfg_data  <= (k == first) ? scale_t'(lo) : scale_t'(hi);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
    settings_used++;
  endtask

  task automatic random_words(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 3) push_word(OP_FRAME, frame_target(), any_coord(), any_coord());
      else push_word(OP_COORD, any_scale(), any_coord(), any_coord());
    end
  endtask

  initial begin
    int a;
    int b;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = REG_MIN_SCALE;
    cfg_data              = '0;
    items_ch.valid        = 1'b0;
    items_ch.op           = OP_FRAME;
    items_ch.target_scale = '0;
    items_ch.coord_x      = '0;
    items_ch.coord_y      = '0;
    burst_left            = 0;
    cur_lo                = MIN_SCALE_RST;
    cur_hi                = MAX_SCALE_RST;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // power-on registers: scale starts at zero, full and weakest steps
    push_word(OP_COORD, 0, 32'h7fff_ffff, 32'h8000_0000);
    push_word(OP_FRAME, SCALE_HI, 32'h1234_5678, 32'h0);
    push_word(OP_FRAME, SCALE_HI, 32'h0, 32'hffff_ffff);
    push_word(OP_COORD, SCALE_LO, 32'h7fff_ffff, 32'h8000_0000);
    push_word(OP_COORD, 0, 32'hffff_ffff, 32'h3);
    push_word(OP_FRAME, 0, 32'h0, 32'h0);
    push_word(OP_COORD, 0, 32'hffff_fffd, 32'h4000_0001);
    push_word(OP_FRAME, SCALE_LO, 32'h0, 32'h0);
    push_word(OP_FRAME, 32768, 32'h0, 32'h0);
    push_word(OP_FRAME, 65535, 32'h0, 32'h0);
    push_word(OP_COORD, 0, 32'h8000_0000, 32'h7fff_ffff);

    // widest span
    drain_block();
    load_scales(SCALE_LO, SCALE_HI);
    push_word(OP_FRAME, SCALE_LO, 32'h0, 32'h0);
    push_word(OP_FRAME, SCALE_HI, 32'h0, 32'h0);
    push_word(OP_FRAME, 0, 32'h0, 32'h0);
    push_word(OP_FRAME, -65535, 32'h0, 32'h0);
    push_word(OP_COORD, 0, 32'h1234_5678, 32'hfedc_ba98);

    // zero span jumps straight to the target, then a negative scale
    drain_block();
    load_scales(32768, 32768);
    push_word(OP_FRAME, SCALE_LO, 32'h0, 32'h0);
    push_word(OP_COORD, 0, 32'h7fff_ffff, 32'h8000_0000);
    push_word(OP_FRAME, SCALE_HI, 32'h0, 32'h0);

    // inverted span also jumps
    drain_block();
    load_scales(SCALE_HI, SCALE_LO);
    push_word(OP_FRAME, 0, 32'h0, 32'h0);
    push_word(OP_FRAME, 12345, 32'h0, 32'h0);
    push_word(OP_COORD, 0, 32'hffff_ffff, 32'hffff_ffff);

    // random phases, one register setting each
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_block();
      a = any_scale();
      b = any_scale();
      case (ph)
        0: load_scales(SCALE_LO, SCALE_HI);
        1: load_scales(MIN_SCALE_RST, MAX_SCALE_RST);
        2: load_scales(a, a);
        3: load_scales((a > b) ? a : b, (a > b) ? b : a);
        4: load_scales(SCALE_HI, SCALE_LO);
        default: begin
          if ($urandom_range(4) == 0) load_scales(a, b);
          else load_scales((a < b) ? a : b, (a < b) ? b : a);
        end
      endcase
      random_words(PHASE_WORDS);
    end

    drain_block();
    repeat (10) @(negedge clk);
    $display("covered %0d frame and %0d coordinate words under %0d register settings",
             frames_checked, coords_checked, settings_used);
    $display("spans full, default, zero and inverted; receiver held off %0d cycles once",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
